@@ src/gwvd_pkg.sv @@
// Package for the Gerstner wave vertex displacement unit.
// Shared types and fixed-point constants; no dependencies.
package gwvd_pkg;

    localparam int DEF_MAX_POINTS = 65536;

    // two pi and pi/2 in Q.16
    localparam logic [18:0] TWO_PI_Q16  = 19'd411775;
    localparam logic [16:0] HALF_PI_Q16 = 17'd102944;

    // offset phase word before reduction: nonneg, below TWO_PI << 22
    localparam int PH_W = 40;
    localparam int MOD_STEPS = 22;

    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
    localparam int T_W = 33;

    typedef struct packed {
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic signed [23:0] z;
    } pos_t;

    typedef struct packed {
        logic [30:0] x;
        logic [1:0]  q;
        pos_t        pos;
    } hside_t;

endpackage

@@ src/gerstner_wave_vertex_displace_unit.sv @@
// Gerstner wave vertex displacement unit, top level.
// Depends on gwvd_pkg, gwvd_mod_cell and gwvd_horner_cell.
//
// Usage:
//   s_tdata carries one vertex item, m_tdata the displaced vertex item.
//   Items are accepted when tvalid and tready are high at a rising edge.
//   Wave registers are written through wr_en / wr_index / wr_data while the
//   block is idle; one wave per pass over the vertices.
// Timing:
//   Fully pipelined, 47 register stages from input to m_tdata. Throughput is one
//   item per cycle while the output is not stalled. The long chain is the phase
//   reduction (22 compare/subtract cells) followed by five Horner cells of three
//   stages for the sine and cosine series.
// Reset:
//   rst_n clears the wave registers and the valid flags, emptying the pipeline.
// Stall:
//   A one-item skid register holds a result the receiver does not take; the
//   whole pipeline then freezes and s_tready drops until the skid drains.
module gerstner_wave_vertex_displace_unit
    import gwvd_pkg::*;
#(
    parameter int MAX_POINTS = DEF_MAX_POINTS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,   // point_index[15:0], pos_x, pos_y, pos_z (24 each)
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // new_x, new_y, new_z (24 each)
    input  logic        wr_en,
    input  logic [2:0]  wr_index,
    input  logic [23:0] wr_data
);

    localparam logic [2:0] R_DIR_X = 3'd0;
    localparam logic [2:0] R_DIR_Y = 3'd1;
    localparam logic [2:0] R_DIR_Z = 3'd2;
    localparam logic [2:0] R_WAVE_NUM = 3'd3;
    localparam logic [2:0] R_TIME_PH = 3'd4;
    localparam logic [2:0] R_HGAIN = 3'd5;
    localparam logic [2:0] R_VAMP = 3'd6;
    localparam logic [2:0] R_ISTEP = 3'd7;

    localparam logic [32:0] MREC = 33'((64'd1 << 32) / MAX_POINTS);
    localparam logic [17:0] MP18 = 18'(MAX_POINTS);
    localparam logic [41:0] PH_OFFSET = 42'(TWO_PI_Q16) << 20;

    function automatic logic signed [23:0] sat24(input logic signed [28:0] v);
        logic signed [23:0] r;
        if (v > 29'sd8388607)
            r = 24'sh7fffff;
        else if (v < -29'sd8388608)
            r = 24'sh800000;
        else
            r = v[23:0];
        return r;
    endfunction

    // configuration
    logic signed [15:0] dir_x_reg, dir_y_reg, dir_z_reg;
    logic [23:0]        wave_number_reg, time_phase_reg, index_step_reg;
    logic signed [23:0] horiz_gain_reg, vert_amp_reg;
    logic signed [39:0] hgdx_reg, hgdz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_x_reg       <= '0;
            dir_y_reg       <= '0;
            dir_z_reg       <= '0;
            wave_number_reg <= '0;
            time_phase_reg  <= '0;
            horiz_gain_reg  <= '0;
            vert_amp_reg    <= '0;
            index_step_reg  <= '0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                R_DIR_X:    dir_x_reg       <= wr_data[15:0];
                R_DIR_Y:    dir_y_reg       <= wr_data[15:0];
                R_DIR_Z:    dir_z_reg       <= wr_data[15:0];
                R_WAVE_NUM: wave_number_reg <= wr_data;
                R_TIME_PH:  time_phase_reg  <= wr_data;
                R_HGAIN:    horiz_gain_reg  <= wr_data;
                R_VAMP:     vert_amp_reg    <= wr_data;
                R_ISTEP:    index_step_reg  <= wr_data;
                default:    ;
            endcase
        end
    end

    // gain products only change with the registers
    always_ff @(posedge clk)
    begin
        hgdx_reg <= horiz_gain_reg * dir_x_reg;
        hgdz_reg <= horiz_gain_reg * dir_z_reg;
    end

    // flow control
    logic        en;
    logic        skid_full_reg;
    logic [71:0] skid_data_reg;
    logic        vo_reg;
    logic [71:0] out_reg;

    assign en       = !skid_full_reg;
    assign s_tready = en;
    assign m_tvalid = skid_full_reg || vo_reg;
    assign m_tdata  = skid_full_reg ? skid_data_reg : out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_full_reg <= 1'b0;
        end
        else if (skid_full_reg)
        begin
            if (m_tready)
                skid_full_reg <= 1'b0;
        end
        else if (vo_reg && !m_tready)
        begin
            skid_full_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!skid_full_reg && vo_reg && !m_tready)
            skid_data_reg <= out_reg;
    end

    // stage 1: direction products and index quotient estimate
    logic [15:0]        in_idx;
    pos_t               in_pos;
    logic [48:0]        iq_full;
    logic               v1_reg;
    logic signed [39:0] mx_reg, my_reg, mz_reg;
    logic [15:0]        idx1_reg, iq1_reg;
    pos_t               pos1_reg;

    assign in_idx   = s_tdata[15:0];
    assign in_pos.x = s_tdata[39:16];
    assign in_pos.y = s_tdata[63:40];
    assign in_pos.z = s_tdata[87:64];
    assign iq_full  = in_idx * MREC;

    // stage 2: dot product, index modulo
    logic signed [41:0] dot;
    logic [17:0]        irem;
    logic [16:0]        idxm;
    logic               v2_reg;
    logic signed [31:0] dot16_reg;
    logic [16:0]        idx2_reg;
    pos_t               pos2_reg;

    always_comb
    begin
        dot  = 42'(mx_reg) + 42'(my_reg) + 42'(mz_reg);
        irem = {2'b0, idx1_reg} - 18'({2'b0, iq1_reg} * MP18);
        idxm = (irem >= MP18) ? 17'(irem - MP18) : irem[16:0];
    end

    // stage 3: wave term and index term products
    logic               v3_reg;
    logic signed [55:0] wprod_reg;
    logic [40:0]        iprod_reg;
    pos_t               pos3_reg;

    // stage 4: phase sum, made nonnegative by a multiple of two pi
    logic signed [55:0] wterm_full;
    logic signed [41:0] ph_sum;
    logic               v4_reg;
    logic [PH_W-1:0]    ph_reg;
    pos_t               pos4_reg;

    always_comb
    begin
        wterm_full = wprod_reg >>> 16;
        ph_sum = 42'(wterm_full) + $signed({9'b0, iprod_reg[40:8]})
               + $signed({18'b0, time_phase_reg}) + $signed(PH_OFFSET);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mx_reg    <= dir_x_reg * in_pos.x;
            my_reg    <= dir_y_reg * in_pos.y;
            mz_reg    <= dir_z_reg * in_pos.z;
            idx1_reg  <= in_idx;
            iq1_reg   <= iq_full[47:32];
            pos1_reg  <= in_pos;
            dot16_reg <= 32'(dot >>> 10);
            idx2_reg  <= idxm;
            pos2_reg  <= pos1_reg;
            wprod_reg <= dot16_reg * $signed({8'b0, wave_number_reg});
            iprod_reg <= (idx2_reg + 17'd1) * index_step_reg;
            pos3_reg  <= pos2_reg;
            ph_reg    <= ph_sum[PH_W-1:0];
            pos4_reg  <= pos3_reg;
        end
    end

    // reduction chain, one bit of quotient per cell
    logic            mv [0:MOD_STEPS];
    logic [PH_W-1:0] mr [0:MOD_STEPS];
    pos_t            mp [0:MOD_STEPS];

    assign mv[0] = v4_reg;
    assign mr[0] = ph_reg;
    assign mp[0] = pos4_reg;

    generate
        for (genvar i = 0; i < MOD_STEPS; i++)
        begin : g_mod
            gwvd_mod_cell #(.SHIFT(MOD_STEPS - 1 - i)) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .en      (en),
                .vld_in  (mv[i]),
                .r_in    (mr[i]),
                .pos_in  (mp[i]),
                .vld_out (mv[i+1]),
                .r_out   (mr[i+1]),
                .pos_out (mp[i+1])
            );
        end
    endgenerate

    // quadrant split
    logic [18:0] phase;
    logic [1:0]  quad;
    logic [16:0] qrem;
    logic        vq_reg, vx2_reg;
    hside_t      sq_reg, sx2_reg;
    logic [31:0] x2_reg;
    logic [61:0] xx;

    assign phase = mr[MOD_STEPS][18:0];

    always_comb
    begin
        if (phase >= 19'(3 * HALF_PI_Q16))
        begin
            quad = 2'd3;
            qrem = 17'(phase - 19'(3 * HALF_PI_Q16));
        end
        else if (phase >= 19'(2 * HALF_PI_Q16))
        begin
            quad = 2'd2;
            qrem = 17'(phase - 19'(2 * HALF_PI_Q16));
        end
        else if (phase >= 19'(HALF_PI_Q16))
        begin
            quad = 2'd1;
            qrem = 17'(phase - 19'(HALF_PI_Q16));
        end
        else
        begin
            quad = 2'd0;
            qrem = phase[16:0];
        end
    end

    assign xx = sq_reg.x * sq_reg.x;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vq_reg  <= 1'b0;
            vx2_reg <= 1'b0;
        end
        else if (en)
        begin
            vq_reg  <= mv[MOD_STEPS];
            vx2_reg <= vq_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_reg.x   <= {qrem, 14'b0};
            sq_reg.q   <= quad;
            sq_reg.pos <= mp[MOD_STEPS];
            sx2_reg    <= sq_reg;
            x2_reg     <= xx[61:30];
        end
    end

    // Horner chain: cosine 90,56,30,12,2; sine 72,42,20,6 from the second cell
    logic                  hv  [0:5];
    logic [31:0]           hx2 [0:5];
    logic signed [T_W-1:0] htc [0:5];
    logic signed [T_W-1:0] hts [0:5];
    hside_t                hs  [0:5];

    assign hv[0]  = vx2_reg;
    assign hx2[0] = x2_reg;
    assign htc[0] = $signed({2'b0, ONE_Q30});
    assign hts[0] = $signed({2'b0, ONE_Q30});
    assign hs[0]  = sx2_reg;

    localparam int KC_TAB [0:4] = '{90, 56, 30, 12, 2};
    localparam int KS_TAB [0:4] = '{0, 72, 42, 20, 6};

    generate
        for (genvar i = 0; i < 5; i++)
        begin : g_horner
            gwvd_horner_cell #(.KC(KC_TAB[i]), .KS(KS_TAB[i])) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .en       (en),
                .vld_in   (hv[i]),
                .x2_in    (hx2[i]),
                .tc_in    (htc[i][30:0]),
                .ts_in    (hts[i][30:0]),
                .side_in  (hs[i]),
                .vld_out  (hv[i+1]),
                .x2_out   (hx2[i+1]),
                .tc_out   (htc[i+1]),
                .ts_out   (hts[i+1]),
                .side_out (hs[i+1])
            );
        end
    endgenerate

    // sine = x * t, then Q1.15 rounding, clamp and quadrant mapping
    logic [61:0]           sprod;
    logic                  vs_reg, vt_reg, vm_reg;
    logic [31:0]           sv_reg;
    logic signed [T_W-1:0] cv_reg;
    logic [1:0]            qs_reg;
    pos_t                  ps_reg, pt_reg, pm_reg;
    logic [32:0]           sr;
    logic signed [33:0]    cr;
    logic [14:0]           s15, c15;
    logic signed [15:0]    sn, cs;
    logic signed [15:0]    sn_reg, cs_reg;
    logic signed [55:0]    mxp_reg, mzp_reg;
    logic signed [39:0]    myp_reg;

    assign sprod = hs[5].x * hts[5][30:0];

    always_comb
    begin
        sr = {1'b0, sv_reg} + 33'd16384;
        s15 = (sr[32:15] > 18'd32767) ? 15'h7fff : sr[29:15];
        cr = 34'(cv_reg) + 34'sd16384;
        if (cr[33])
            c15 = 15'd0;
        else if (cr[32:15] > 18'd32767)
            c15 = 15'h7fff;
        else
            c15 = cr[29:15];
        case (qs_reg)
            2'd0:
            begin
                sn = $signed({1'b0, s15});
                cs = $signed({1'b0, c15});
            end
            2'd1:
            begin
                sn = $signed({1'b0, c15});
                cs = -$signed({1'b0, s15});
            end
            2'd2:
            begin
                sn = -$signed({1'b0, s15});
                cs = -$signed({1'b0, c15});
            end
            default:
            begin
                sn = -$signed({1'b0, c15});
                cs = $signed({1'b0, s15});
            end
        endcase
    end

    // output: round, add to position, saturate
    logic signed [55:0] xr, zr;
    logic signed [39:0] yr;
    logic signed [28:0] ox, oy, oz;

    always_comb
    begin
        xr = (mxp_reg + 56'sd268435456) >>> 29;
        zr = (mzp_reg + 56'sd268435456) >>> 29;
        yr = (myp_reg + 40'sd16384) >>> 15;
        ox = 29'(pm_reg.x) + 29'(xr);
        oy = 29'(pm_reg.y) + 29'(yr);
        oz = 29'(pm_reg.z) + 29'(zr);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vs_reg <= 1'b0;
            vt_reg <= 1'b0;
            vm_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else if (en)
        begin
            vs_reg <= hv[5];
            vt_reg <= vs_reg;
            vm_reg <= vt_reg;
            vo_reg <= vm_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sv_reg  <= sprod[61:30];
            cv_reg  <= htc[5];
            qs_reg  <= hs[5].q;
            ps_reg  <= hs[5].pos;
            sn_reg  <= sn;
            cs_reg  <= cs;
            pt_reg  <= ps_reg;
            mxp_reg <= hgdx_reg * cs_reg;
            mzp_reg <= hgdz_reg * cs_reg;
            myp_reg <= vert_amp_reg * sn_reg;
            pm_reg  <= pt_reg;
            out_reg <= {sat24(oz), sat24(oy), sat24(ox)};
        end
    end

endmodule

@@ src/gwvd_mod_cell.sv @@
// One step of the phase reduction: subtract two pi << SHIFT if it fits.
// Depends on gwvd_pkg.
module gwvd_mod_cell
    import gwvd_pkg::*;
#(
    parameter int SHIFT = 0
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            vld_in,
    input  logic [PH_W-1:0] r_in,
    input  pos_t            pos_in,
    output logic            vld_out,
    output logic [PH_W-1:0] r_out,
    output pos_t            pos_out
);

    localparam logic [PH_W-1:0] MODV = PH_W'(TWO_PI_Q16) << SHIFT;

    logic            vld_reg;
    logic [PH_W-1:0] r_reg;
    logic [PH_W-1:0] r_next;
    pos_t            pos_reg;

    assign r_next = (r_in >= MODV) ? (r_in - MODV) : r_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg   <= r_next;
            pos_reg <= pos_in;
        end
    end

    assign vld_out = vld_reg;
    assign r_out   = r_reg;
    assign pos_out = pos_reg;

endmodule

@@ src/gwvd_horner_cell.sv @@
// One Horner step for the cosine and sine series: t = 1 - floor(x2*t)/K.
// Three register stages; depends on gwvd_pkg. KS of zero passes sine through.
module gwvd_horner_cell
    import gwvd_pkg::*;
#(
    parameter int KC = 2,
    parameter int KS = 0
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  vld_in,
    input  logic [31:0]           x2_in,
    input  logic [30:0]           tc_in,
    input  logic [30:0]           ts_in,
    input  hside_t                side_in,
    output logic                  vld_out,
    output logic [31:0]           x2_out,
    output logic signed [T_W-1:0] tc_out,
    output logic signed [T_W-1:0] ts_out,
    output hside_t                side_out
);

    // reciprocal, quotient estimate is low by at most one
    localparam logic [31:0] MC = 32'((64'd1 << 32) / KC);

    logic [2:0]  vld_reg;
    logic [31:0] x2_a_reg, x2_b_reg, x2_c_reg;
    hside_t      side_a_reg, side_b_reg, side_c_reg;
    logic [62:0] pc_a_reg;
    logic [31:0] yc_b_reg;
    logic [63:0] mc_b_reg;
    logic signed [T_W-1:0] tc_c_reg;
    logic signed [T_W-1:0] tc_next;
    logic [31:0] qc0, qc;
    logic [32:0] remc;

    always_comb
    begin
        qc0     = mc_b_reg[63:32];
        remc    = {1'b0, yc_b_reg} - 33'({1'b0, qc0} * 33'(KC));
        qc      = qc0 + 32'(remc >= 33'(KC));
        tc_next = $signed({2'b0, ONE_Q30}) - $signed({1'b0, qc});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[1:0], vld_in};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x2_a_reg   <= x2_in;
            side_a_reg <= side_in;
            pc_a_reg   <= x2_in * tc_in;
            x2_b_reg   <= x2_a_reg;
            side_b_reg <= side_a_reg;
            yc_b_reg   <= pc_a_reg[61:30];
            mc_b_reg   <= pc_a_reg[61:30] * MC;
            x2_c_reg   <= x2_b_reg;
            side_c_reg <= side_b_reg;
            tc_c_reg   <= tc_next;
        end
    end

    generate
        if (KS == 0)
        begin : g_pass
            logic [30:0] ts_a_reg, ts_b_reg, ts_c_reg;
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    ts_a_reg <= ts_in;
                    ts_b_reg <= ts_a_reg;
                    ts_c_reg <= ts_b_reg;
                end
            end
            assign ts_out = $signed({2'b0, ts_c_reg});
        end
        else
        begin : g_sin
            localparam logic [31:0] MS = 32'((64'd1 << 32) / KS);
            logic [62:0] ps_a_reg;
            logic [31:0] ys_b_reg;
            logic [63:0] ms_b_reg;
            logic signed [T_W-1:0] ts_c_reg;
            logic signed [T_W-1:0] ts_next;
            logic [31:0] qs0, qs;
            logic [32:0] rems;

            always_comb
            begin
                qs0     = ms_b_reg[63:32];
                rems    = {1'b0, ys_b_reg} - 33'({1'b0, qs0} * 33'(KS));
                qs      = qs0 + 32'(rems >= 33'(KS));
                ts_next = $signed({2'b0, ONE_Q30}) - $signed({1'b0, qs});
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    ps_a_reg <= x2_in * ts_in;
                    ys_b_reg <= ps_a_reg[61:30];
                    ms_b_reg <= ps_a_reg[61:30] * MS;
                    ts_c_reg <= ts_next;
                end
            end
            assign ts_out = ts_c_reg;
        end
    endgenerate

    assign vld_out  = vld_reg[2];
    assign x2_out   = x2_c_reg;
    assign tc_out   = tc_c_reg;
    assign side_out = side_c_reg;

endmodule

@@ bench/tb_top.sv @@
// Testbench for gerstner_wave_vertex_displace_unit: random and directed vertex items
// checked against a bit-exact behavioral predictor of the wave displacement.
// Depends on gwvd_pkg and the unit's RTL.
module tb_top;
    import gwvd_pkg::*;

    localparam int REG_DIR_X = 0, REG_DIR_Y = 1, REG_DIR_Z = 2, REG_WAVE_NUMBER = 3;
    localparam int REG_TIME_PHASE = 4, REG_HORIZ_GAIN = 5, REG_VERT_AMP = 6;
    localparam int REG_INDEX_STEP = 7;
    localparam int PIPE_DRAIN = 60;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam longint TWO_PI = 411775;
    localparam longint HALF_PI = 102944;
    localparam longint ONE30 = 64'sd1 << 30;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [87:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [71:0] m_tdata;
    logic        wr_en = 0;
    logic [2:0]  wr_index = '0;
    logic [23:0] wr_data = '0;

    gerstner_wave_vertex_displace_unit u_dut (.*);

    always #5 clk = ~clk;

    logic [23:0] wave_reg [8];
    logic [87:0] pending_vertices [$];
    logic [71:0] expected_vertices [$];
    int          mismatches = 0;
    int          quiet_cycles = 0;
    bit          calm = 0;       // no idling on either side
    bit          hold_send = 0;

    function automatic longint sext(longint v, int w);
        longint m;
        m = (64'sd1 << w) - 1;
        v = v & m;
        if (v[w-1])
            v = v - (64'sd1 << w);
        return v;
    endfunction

    function automatic longint fshr(longint p, int s);
        return p >>> s;
    endfunction

    function automatic longint m30(longint a, longint b);
        return fshr(a * b, 30);
    endfunction

    function automatic longint q15_clamp(longint v);
        longint r;
        r = fshr(v + (64'sd1 << 14), 15);
        if (r < 0) r = 0;
        if (r > 32767) r = 32767;
        return r;
    endfunction

    function automatic longint sat24(longint v);
        if (v > 8388607) return 8388607;
        if (v < -8388608) return -8388608;
        return v;
    endfunction

    // Expected displaced vertex for one input item under the current wave registers
    function automatic logic [71:0] displace_vertex(logic [87:0] d);
        longint dx, dy, dz, wn, tp, hg, va, stp, idx, px, py, pz;
        longint dot, wterm, iterm, phase, q, r, x, x2, t, s, c, sn, cs, ox, oy, oz;
        dx = sext(wave_reg[REG_DIR_X], 16);
        dy = sext(wave_reg[REG_DIR_Y], 16);
        dz = sext(wave_reg[REG_DIR_Z], 16);
        wn = wave_reg[REG_WAVE_NUMBER];
        tp = wave_reg[REG_TIME_PHASE];
        hg = sext(wave_reg[REG_HORIZ_GAIN], 24);
        va = sext(wave_reg[REG_VERT_AMP], 24);
        stp = wave_reg[REG_INDEX_STEP];
        idx = d[15:0];
        px = sext(d[39:16], 24);
        py = sext(d[63:40], 24);
        pz = sext(d[87:64], 24);
        dot = dx * px + dy * py + dz * pz;
        wterm = fshr(fshr(dot, 10) * wn, 16);
        iterm = ((idx + 1) * stp) >> 8;
        phase = (iterm + wterm + tp) % TWO_PI;
        if (phase < 0) phase += TWO_PI;
        q = phase / HALF_PI;
        r = phase - q * HALF_PI;
        x = r <<< 14;
        x2 = m30(x, x);
        t = ONE30 - x2 / 72;
        t = ONE30 - m30(x2, t) / 42;
        t = ONE30 - m30(x2, t) / 20;
        t = ONE30 - m30(x2, t) / 6;
        s = q15_clamp(m30(x, t));
        t = ONE30 - x2 / 90;
        t = ONE30 - m30(x2, t) / 56;
        t = ONE30 - m30(x2, t) / 30;
        t = ONE30 - m30(x2, t) / 12;
        t = ONE30 - m30(x2, t) / 2;
        c = q15_clamp(t);
        case (q & 3)
            0: begin sn = s;  cs = c;  end
            1: begin sn = c;  cs = -s; end
            2: begin sn = -s; cs = -c; end
            default: begin sn = -c; cs = s; end
        endcase
        ox = sat24(px + fshr(hg * dx * cs + (64'sd1 << 28), 29));
        oz = sat24(pz + fshr(hg * dz * cs + (64'sd1 << 28), 29));
        oy = sat24(py + fshr(va * sn + (64'sd1 << 14), 15));
        return {oz[23:0], oy[23:0], ox[23:0]};
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                expected_vertices.push_back(displace_vertex(s_tdata));
            if (!(s_tvalid && !s_tready))
            begin
                if (!hold_send && pending_vertices.size() > 0
                    && (calm || $urandom_range(99) >= 11))
                begin
                    s_tvalid <= 1'b1;
                    s_tdata <= pending_vertices.pop_front();
                end
                else
                    s_tvalid <= 1'b0;
            end
            m_tready <= calm || $urandom_range(99) >= 11;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (m_tvalid && m_tready)
            begin
                if (expected_vertices.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected item %h", m_tdata);
                end
                else
                begin
                    logic [71:0] e;
                    e = expected_vertices.pop_front();
                    for (int f = 0; f < 3; f++)
                        if (e[f*24 +: 24] !== m_tdata[f*24 +: 24])
                        begin
                            mismatches++;
                            if (mismatches <= 10)
                                $display("field %0d: expected %h got %h",
                                         f, e[f*24 +: 24], m_tdata[f*24 +: 24]);
                        end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[gerstner_wave_vertex_displace_unit] ERROR");
            $finish;
        end
    end

    task automatic write_reg(int idx, logic [23:0] v);
        @(posedge clk);
        wr_en <= 1'b1;
        wr_index <= idx[2:0];
        wr_data <= v;
        wave_reg[idx] = (idx <= REG_DIR_Z) ? {8'd0, v[15:0]} : v;
        @(posedge clk);
        wr_en <= 1'b0;
    endtask

    task automatic wait_drained();
        wait (pending_vertices.size() == 0);
        @(posedge clk);
        while (s_tvalid || expected_vertices.size() > 0)
            @(posedge clk);
        repeat (PIPE_DRAIN) @(posedge clk);
    endtask

    task automatic random_wave(bit extreme);
        for (int i = 0; i < 8; i++)
        begin
            logic [23:0] v;
            v = 24'($urandom);
            if (extreme)
                case ($urandom_range(2))
                    0: v = 24'h7FFFFF;
                    1: v = 24'h800000;
                    default: v = 24'hFFFFFF;
                endcase
            else if (i == REG_HORIZ_GAIN || i == REG_VERT_AMP)
                v = $urandom_range(3) == 0 ? v : {{6{v[17]}}, v[17:0]};
            write_reg(i, v);
        end
    endtask

    function automatic logic [87:0] rand_vertex();
        logic [23:0] x, y, z;
        x = 24'($urandom); y = 24'($urandom); z = 24'($urandom);
        if ($urandom_range(3) != 0)
        begin
            x = {{6{x[17]}}, x[17:0]};
            y = {{6{y[17]}}, y[17:0]};
            z = {{6{z[17]}}, z[17:0]};
        end
        return {z, y, x, 16'($urandom)};
    endfunction

    initial
    begin
        for (int i = 0; i < 8; i++)
            wave_reg[i] = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1;

        // directed: field extremes, disabled wave first
        pending_vertices.push_back({24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 16'hFFFF});
        pending_vertices.push_back({24'h800000, 24'h800000, 24'h800000, 16'h0000});
        wait_drained();
        write_reg(REG_DIR_X, 24'h4000);
        write_reg(REG_DIR_Y, 24'h8000);
        write_reg(REG_DIR_Z, 24'h7FFF);
        write_reg(REG_WAVE_NUMBER, 24'h010000);
        write_reg(REG_HORIZ_GAIN, 24'h7FFFFF);
        write_reg(REG_VERT_AMP, 24'h7FFFFF);
        write_reg(REG_INDEX_STEP, 24'hFFFFFF);
        // phases on and between quadrant borders, incl. sine of one and the short last quadrant
        for (int k = 0; k < 8; k++)
        begin
            write_reg(REG_TIME_PHASE,
                      24'(k * 102944 / 2
                          + (k == 7 ? 102944 * 3 + 102943 - 360415 : 0)));
            write_reg(REG_INDEX_STEP, 24'h0);
            write_reg(REG_WAVE_NUMBER, 24'h0);
            pending_vertices.push_back({24'h7FF000, 24'h7FFFFF, 24'h800000, 16'($urandom)});
            pending_vertices.push_back({24'h000000, 24'h800000, 24'h7FFFFF, 16'hFFFF});
            wait_drained();
        end
        write_reg(REG_TIME_PHASE, 24'd411774);
        write_reg(REG_VERT_AMP, 24'h800000);
        write_reg(REG_HORIZ_GAIN, 24'h800000);
        pending_vertices.push_back({24'h7FFFFF, 24'h800000, 24'h800000, 16'h0});
        wait_drained();

        // random passes, one wave each
        for (int pass = 0; pass < 17; pass++)
        begin
            random_wave(pass % 5 == 4);
            calm = (pass == 3);
            for (int n = 0; n < 100; n++)
                pending_vertices.push_back(rand_vertex());
            if (pass == 8)
            begin
                // sender holds off until every result has come back
                wait (pending_vertices.size() < 50);
                hold_send = 1;
                while (s_tvalid || expected_vertices.size() > 0)
                    @(posedge clk);
                hold_send = 0;
            end
            wait_drained();
        end

        if (mismatches == 0)
            $display("[gerstner_wave_vertex_displace_unit] OK");
        else
            $display("[gerstner_wave_vertex_displace_unit] ERROR");
        $finish;
    end
endmodule
